@@ sv/ogpc_pkg.sv @@
// Types, constants and helpers for the odometry go-to-point controller.
// Used by odometry_go_to_point_controller_unit; depends on nothing.
`default_nettype none

package ogpc_pkg;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [26:0] KINV_Q16    = 27'sd39797;
    localparam int                 ATAN_ENTRIES = 24;
    localparam int                 ATAN_IDX_W   = 5;

    localparam logic signed [32:0] ATAN_Q28 [ATAN_ENTRIES] = '{
        33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
        33'sd16755422,  33'sd8385879,   33'sd4193963,  33'sd2097109,
        33'sd1048571,   33'sd524287,    33'sd262144,   33'sd131072,
        33'sd65536,     33'sd32768,     33'sd16384,    33'sd8192,
        33'sd4096,      33'sd2048,      33'sd1024,     33'sd512,
        33'sd256,       33'sd128,       33'sd64,       33'sd32
    };

    typedef enum logic [2:0] {
        CFG_DEST_X         = 3'd0,
        CFG_DEST_Y         = 3'd1,
        CFG_DISTANCE_GAIN  = 3'd2,
        CFG_HEADING_GAIN   = 3'd3,
        CFG_REACH_RADIUS   = 3'd4,
        CFG_DISTANCE_CLAMP = 3'd5,
        CFG_EFFORT_LIMIT   = 3'd6,
        CFG_DRIVE_ENABLE   = 3'd7
    } cfg_index_t;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_ROT  = 18'h00002,
        S_POSX = 18'h00004,
        S_POSY = 18'h00008,
        S_HEAD = 18'h00010,
        S_DIFF = 18'h00020,
        S_SQX  = 18'h00040,
        S_SQY  = 18'h00080,
        S_RR   = 18'h00100,
        S_CMP  = 18'h00200,
        S_VEC  = 18'h00400,
        S_MAG  = 18'h00800,
        S_ERR  = 18'h01000,
        S_DG   = 18'h02000,
        S_DC   = 18'h04000,
        S_TURN = 18'h08000,
        S_EFF  = 18'h10000,
        S_DONE = 18'h20000
    } state_t;

    typedef struct packed {
        logic signed [32:0] z;
        logic               neg;
    } rot_init_t;

    // Wrap once into +-pi, fold into +-pi/2, scale Q.13 to Q.28.
    function automatic rot_init_t rot_setup(input logic signed [17:0] ang);
        logic signed [17:0] t;
        rot_init_t          r;
        t = ang;
        if (t > PI_Q13) begin
            t = t - TWO_PI_Q13;
        end else if (t < -PI_Q13) begin
            t = t + TWO_PI_Q13;
        end
        r.neg = 1'b0;
        if (t > HALF_PI_Q13) begin
            t = t - PI_Q13;
            r.neg = 1'b1;
        end else if (t < -HALF_PI_Q13) begin
            t = t + PI_Q13;
            r.neg = 1'b1;
        end
        r.z = {t, 15'd0};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/odometry_go_to_point_controller_unit.sv @@
// Odometry go-to-point controller: pose update, distance/bearing and wheel efforts.
// One shared CORDIC stage and one shared multiplier under a one-hot sequencer.
// Depends on ogpc_pkg.
//
// Each input beat runs the shared CORDIC stage: one rotation for the pose update
// and, with driving enabled, a vectoring pass (skipped when the destination sits
// on the pose) and a second rotation; with driving disabled only the pose-update
// rotation runs. Each product takes one pass through the shared multiplier. A
// finished result also waits while the output register still holds an unaccepted
// beat. s_tready is high only between items. The result sits in an output
// register, so the next item may start while it waits.
`default_nettype none

module odometry_go_to_point_controller_unit #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] forward_step, [30:16] turn_step, [31] zero
    input  wire logic [31:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [23:0] pos_x, [47:24] pos_y, [63:48] heading, [79:64] turn_count,
    // [80] reached, [97:81] left_drv, [114:98] right_drv, [119:115] zero
    output logic [119:0]      m_tdata,
    // [0] effort_valid
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wr_data
);
    import ogpc_pkg::*;

    localparam int ITW = $clog2(CORDIC_ITERATIONS);
    localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_ITERATIONS - 1);

    state_t state_reg, state_next;
    logic [ITW-1:0] iter_reg;
    logic rot2_reg;
    logic m_tvalid_reg;
    logic [119:0] m_tdata_reg;
    logic [0:0] m_tuser_reg;

    logic signed [23:0] dest_x_reg, dest_y_reg;
    logic [9:0] dist_gain_reg;
    logic [11:0] head_gain_reg;
    logic [15:0] reach_reg, clamp_reg, limit_reg;
    logic drv_en_reg;

    logic signed [23:0] pose_x_reg, pose_y_reg;
    logic signed [15:0] head_reg;
    logic [15:0] wrap_reg;

    logic signed [35:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic cneg_reg;
    logic signed [15:0] fwd_reg;
    logic signed [17:0] h2_reg, th_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [62:0] prod_reg;
    logic [50:0] acc_reg;
    logic reached_reg;
    logic signed [17:0] bear_reg, err_reg;
    logic [15:0] dc_reg;
    logic signed [29:0] drive_reg;
    logic signed [16:0] left_reg, right_reg;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [29:0] v,
                                                 input logic signed [29:0] lim);
        logic signed [16:0] r;
        if (v > lim) begin
            r = lim[16:0];
        end else if (v < -lim) begin
            r = 17'(-lim);
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    // input unpack and first half turn
    logic signed [15:0] fwd_in;
    logic signed [17:0] trn_in, h1_in, h2_in, theta_in;
    assign fwd_in   = s_tdata[15:0];
    assign trn_in   = 18'($signed(s_tdata[30:16]));
    assign h1_in    = trn_in >>> 1;
    assign h2_in    = trn_in - h1_in;
    assign theta_in = 18'(head_reg) + h1_in;

    // shared CORDIC stage
    logic signed [35:0] cx_sh, cy_sh, cx_step, cy_step;
    logic signed [32:0] atan_v, cz_step;
    logic step_pos;
    assign cx_sh  = cx_reg >>> iter_reg;
    assign cy_sh  = cy_reg >>> iter_reg;
    assign atan_v = ATAN_Q28[ATAN_IDX_W'(iter_reg)];
    assign step_pos = (state_reg == S_VEC) ? (cy_reg <= 36'sd0) : (cz_reg >= 33'sd0);
    always_comb begin
        if (step_pos) begin
            cx_step = cx_reg - cy_sh;
            cy_step = cy_reg + cx_sh;
            cz_step = cz_reg - atan_v;
        end else begin
            cx_step = cx_reg + cy_sh;
            cy_step = cy_reg - cx_sh;
            cz_step = cz_reg + atan_v;
        end
    end

    logic signed [35:0] c_val, s_val, c_abs;
    assign c_val = cneg_reg ? -cx_reg : cx_reg;
    assign s_val = cneg_reg ? -cy_reg : cy_reg;
    assign c_abs = c_val[35] ? -c_val : c_val;

    // rounding taps of the product register and the CORDIC angle
    logic signed [62:0] r16, r24, r5;
    logic signed [32:0] r15z;
    assign r16  = (prod_reg + 63'sd32768) >>> 16;
    assign r24  = (prod_reg + 63'sd8388608) >>> 24;
    assign r5   = (prod_reg + 63'sd16) >>> 5;
    assign r15z = (cz_reg + 33'sd16384) >>> 15;

    logic signed [25:0] px_sum, py_sum;
    assign px_sum = 26'(pose_x_reg) + $signed(r16[25:0]);
    assign py_sum = 26'(pose_y_reg) + $signed(r16[25:0]);

    logic signed [17:0] th_new;
    assign th_new = th_reg + h2_reg;

    logic signed [17:0] err_d, err_w;
    always_comb begin
        err_d = bear_reg - 18'(head_reg);
        err_w = err_d;
        if (err_d > PI_Q13) begin
            err_w = err_d - TWO_PI_Q13;
        end else if (err_d < -PI_Q13) begin
            err_w = err_d + TWO_PI_Q13;
        end
    end

    logic [15:0] dc_w;
    assign dc_w = (r24 > $signed({47'd0, clamp_reg})) ? clamp_reg : r24[15:0];

    rot_init_t rot_in;
    assign rot_in = rot_setup((state_reg == S_IDLE) ? theta_in : err_w);

    logic signed [29:0] lim30, turn_w;
    assign lim30  = $signed({14'd0, limit_reg});
    assign turn_w = r5[29:0];

    logic signed [35:0] vx_init, vy_init;
    assign vx_init = 36'($signed({dx_reg, 8'd0}));
    assign vy_init = 36'($signed({dy_reg, 8'd0}));

    // shared multiplier
    logic signed [35:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [62:0] mul_p;
    always_comb begin
        mul_a = 36'(fwd_reg);
        mul_b = c_val[26:0];
        case (state_reg)
            S_POSX: begin
                mul_a = 36'(fwd_reg);
                mul_b = c_val[26:0];
            end
            S_POSY: begin
                mul_a = 36'(fwd_reg);
                mul_b = s_val[26:0];
            end
            S_SQX: begin
                mul_a = 36'(dx_reg);
                mul_b = 27'(dx_reg);
            end
            S_SQY: begin
                mul_a = 36'(dy_reg);
                mul_b = 27'(dy_reg);
            end
            S_RR: begin
                mul_a = $signed({20'd0, reach_reg});
                mul_b = $signed({11'd0, reach_reg});
            end
            S_MAG: begin
                mul_a = cx_reg;
                mul_b = KINV_Q16;
            end
            S_DG: begin
                mul_a = $signed({20'd0, dc_reg});
                mul_b = $signed({17'd0, dist_gain_reg});
            end
            S_DC: begin
                mul_a = $signed(prod_reg[35:0]);
                mul_b = c_abs[26:0];
            end
            S_TURN: begin
                mul_a = 36'(err_reg);
                mul_b = $signed({15'd0, head_gain_reg});
            end
            default: begin
                mul_a = 36'(fwd_reg);
                mul_b = c_val[26:0];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_ROT;
            S_ROT: begin
                if (iter_reg == ITER_LAST) state_next = rot2_reg ? S_DG : S_POSX;
            end
            S_POSX: state_next = S_POSY;
            S_POSY: state_next = S_HEAD;
            S_HEAD: state_next = S_DIFF;
            S_DIFF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_RR;
            S_RR:   state_next = S_CMP;
            S_CMP: begin
                if (!drv_en_reg) begin
                    state_next = S_DONE;
                end else if (dx_reg == 25'sd0 && dy_reg == 25'sd0) begin
                    state_next = S_MAG;
                end else begin
                    state_next = S_VEC;
                end
            end
            S_VEC:  if (iter_reg == ITER_LAST) state_next = S_MAG;
            S_MAG:  state_next = S_ERR;
            S_ERR:  state_next = S_ROT;
            S_DG:   state_next = S_DC;
            S_DC:   state_next = S_TURN;
            S_TURN: state_next = S_EFF;
            S_EFF:  state_next = S_DONE;
            S_DONE: if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and pose state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            rot2_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            wrap_reg      <= '0;
            dest_x_reg    <= '0;
            dest_y_reg    <= '0;
            dist_gain_reg <= 10'd7;
            head_gain_reg <= 12'd300;
            reach_reg     <= 16'd768;
            clamp_reg     <= 16'd12800;
            limit_reg     <= 16'd38400;
            drv_en_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_ROT || state_reg == S_VEC) begin
                iter_reg <= (iter_reg == ITER_LAST) ? '0 : iter_reg + 1'b1;
            end else begin
                iter_reg <= '0;
            end
            if (state_reg == S_IDLE) rot2_reg <= 1'b0;
            if (state_reg == S_ERR) rot2_reg <= 1'b1;
            if (state_reg == S_POSY) pose_x_reg <= sat24(px_sum);
            if (state_reg == S_HEAD) begin
                pose_y_reg <= sat24(py_sum);
                if (th_new > PI_Q13) begin
                    head_reg <= 16'(th_new - TWO_PI_Q13);
                    wrap_reg <= wrap_reg + 16'd1;
                end else if (th_new < -PI_Q13) begin
                    head_reg <= 16'(th_new + TWO_PI_Q13);
                end else begin
                    head_reg <= th_new[15:0];
                end
            end
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_DEST_X:         dest_x_reg    <= cfg_wr_data;
                    CFG_DEST_Y:         dest_y_reg    <= cfg_wr_data;
                    CFG_DISTANCE_GAIN:  dist_gain_reg <= cfg_wr_data[9:0];
                    CFG_HEADING_GAIN:   head_gain_reg <= cfg_wr_data[11:0];
                    CFG_REACH_RADIUS:   reach_reg     <= cfg_wr_data[15:0];
                    CFG_DISTANCE_CLAMP: clamp_reg     <= cfg_wr_data[15:0];
                    CFG_EFFORT_LIMIT:   limit_reg     <= cfg_wr_data[15:0];
                    CFG_DRIVE_ENABLE:   drv_en_reg    <= cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                fwd_reg  <= fwd_in;
                h2_reg   <= h2_in;
                th_reg   <= theta_in;
                cx_reg   <= 36'(KINV_Q16);
                cy_reg   <= '0;
                cz_reg   <= rot_in.z;
                cneg_reg <= rot_in.neg;
            end
            S_ROT, S_VEC: begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
            end
            S_POSX, S_POSY, S_SQX, S_MAG, S_DG, S_DC: prod_reg <= mul_p;
            S_DIFF: begin
                dx_reg <= 25'(dest_x_reg) - 25'(pose_x_reg);
                dy_reg <= 25'(dest_y_reg) - 25'(pose_y_reg);
            end
            S_SQY: begin
                acc_reg  <= prod_reg[50:0];
                prod_reg <= mul_p;
            end
            S_RR: begin
                acc_reg  <= acc_reg + prod_reg[50:0];
                prod_reg <= mul_p;
            end
            S_HEAD: ;
            S_CMP: begin
                reached_reg <= acc_reg < prod_reg[50:0];
                left_reg    <= '0;
                right_reg   <= '0;
                if (vx_init < 36'sd0) begin
                    cx_reg <= -vx_init;
                    cy_reg <= -vy_init;
                    cz_reg <= (vy_init >= 36'sd0) ? PI_Q28 : -PI_Q28;
                end else begin
                    cx_reg <= vx_init;
                    cy_reg <= vy_init;
                    cz_reg <= '0;
                end
            end
            S_ERR: begin
                dc_reg   <= dc_w;
                err_reg  <= err_w;
                cx_reg   <= 36'(KINV_Q16);
                cy_reg   <= '0;
                cz_reg   <= rot_in.z;
                cneg_reg <= rot_in.neg;
            end
            S_TURN: begin
                drive_reg <= r16[29:0];
                prod_reg  <= mul_p;
            end
            S_EFF: begin
                left_reg  <= sat17(drive_reg - turn_w, lim30);
                right_reg <= sat17(drive_reg + turn_w, lim30);
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {5'd0, right_reg, left_reg, reached_reg, wrap_reg,
                                    head_reg, pose_y_reg, pose_x_reg};
                    m_tuser_reg <= drv_en_reg;
                end
            end
            default: ;
        endcase
        if (state_reg == S_MAG) bear_reg <= r15z[17:0];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_ROT))
        else $error("accepted beat did not start rotation");

    a_effort_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[114:81] == 34'd0))
        else $error("efforts nonzero while driving disabled");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[63:48]) <= 16'sd25736 &&
                      $signed(m_tdata[63:48]) >= -16'sd25736))
        else $error("heading out of range");

    a_vec_when_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VEC) |-> drv_en_reg)
        else $error("vectoring while driving disabled");

endmodule

`default_nettype wire
